/* sv/ctc_pkg.sv */
package ctc_pkg;

    localparam int SQ_STEPS = 32;
    localparam int DV_STEPS = 33;
    localparam int LANE_LAT = 3 + 1 + SQ_STEPS + 1 + DV_STEPS + 1;
    localparam int N_LANES  = 3;

    localparam logic [30:0] RADIUS_RST = 31'd65536;

    localparam logic [1:0] EDGE_12 = 2'd0;
    localparam logic [1:0] EDGE_13 = 2'd1;
    localparam logic [1:0] EDGE_23 = 2'd2;
    localparam logic [1:0] EDGE_CODE [N_LANES] = '{EDGE_12, EDGE_13, EDGE_23};

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq;

    typedef struct packed {
        logic [32:0] rem;
        logic [32:0] lo;
    } t_dv;

    typedef struct packed {
        logic               ok;
        logic [32:0]        sep;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } t_lane_res;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_side;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               collided;
        logic [1:0]         hit_edge;
    } t_out;

    function automatic logic signed [31:0] sdiff(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d > 33'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (d < -33'sd2147483647) begin
            return 32'sh80000001;
        end
        return d[31:0];
    endfunction

    function automatic logic signed [63:0] smul32(logic signed [31:0] a, logic signed [31:0] b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic t_sq sq_step(t_sq s, logic [5:0] sh);
        logic [63:0] bitv;
        logic [63:0] sum;
        t_sq         o;
        bitv = 64'd1 << sh;
        sum  = s.r + bitv;
        if (s.v >= sum) begin
            o.v = s.v - sum;
            o.r = (s.r >> 1) + bitv;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic t_dv dv_init(logic [63:0] n);
        t_dv o;
        o.rem = {2'b00, n[63:33]};
        o.lo  = n[32:0];
        return o;
    endfunction

    function automatic t_dv dv_step(t_dv s, logic [31:0] d);
        logic [32:0] t;
        logic        ge;
        t_dv         o;
        t     = {s.rem[31:0], s.lo[32]};
        ge    = (t >= {1'b0, d});
        o.rem = ge ? (t - {1'b0, d}) : t;
        o.lo  = {s.lo[31:0], ge};
        return o;
    endfunction

    function automatic logic signed [41:0] trunc30(logic signed [71:0] x);
        logic signed [71:0] b;
        b = x + (x[71] ? 72'sd1073741823 : 72'sd0);
        return 42'(b >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [41:0] x);
        if (x > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

/* sv/ctc_in_if.sv */
interface ctc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v3_x;
    logic signed [31:0] v3_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
                    pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink (input valid, v1_x, v1_y, v2_x, v2_y, v3_x, v3_y,
                  pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

/* sv/ctc_out_if.sv */
interface ctc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               collided;
    logic [1:0]         hit_edge;

    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    collided, hit_edge, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  collided, hit_edge, output ready);
endinterface

/* sv/ctc_lane.sv */
module ctc_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_ax,
    input  logic signed [31:0]  i_ay,
    input  logic signed [31:0]  i_bx,
    input  logic signed [31:0]  i_by,
    input  logic signed [31:0]  i_px,
    input  logic signed [31:0]  i_py,
    output ctc_pkg::t_lane_res  o_res
);
    import ctc_pkg::*;

    typedef struct packed {
        logic signed [31:0] dx, dy, wx, wy, ux, uy;
    } t_s1;

    typedef struct packed {
        logic signed [63:0] xx, yy, xw, yw, xwy, ywx, wxx, wyy, uxx, uyy;
        logic signed [31:0] dx, dy;
    } t_s2;

    typedef struct packed {
        logic [63:0]        len2, ww, uu;
        logic signed [63:0] t, cr;
        logic signed [31:0] dx, dy;
    } t_s3;

    typedef struct packed {
        t_sq         a, b;
        logic [63:0] acr;
        logic [31:0] exm, eym;
        logic        exn, eyn, crz, ok, perp;
    } t_sp;

    typedef struct packed {
        t_dv         q, x, y;
        logic [31:0] len, dsq;
        logic        exn, eyn, crz, ok, perp;
    } t_dp;

    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_s3       r_s3, n_s3;
    t_sp       r_sp [0:SQ_STEPS];
    t_sp       n_sp [0:SQ_STEPS];
    t_dp       r_dp [0:DV_STEPS];
    t_dp       n_dp [0:DV_STEPS];
    t_lane_res r_res, n_res;

    always_comb begin
        n_s1.dx = sdiff(i_bx, i_ax);
        n_s1.dy = sdiff(i_by, i_ay);
        n_s1.wx = sdiff(i_px, i_ax);
        n_s1.wy = sdiff(i_py, i_ay);
        n_s1.ux = sdiff(i_px, i_bx);
        n_s1.uy = sdiff(i_py, i_by);
    end

    always_comb begin
        n_s2.xx  = smul32(r_s1.dx, r_s1.dx);
        n_s2.yy  = smul32(r_s1.dy, r_s1.dy);
        n_s2.xw  = smul32(r_s1.dx, r_s1.wx);
        n_s2.yw  = smul32(r_s1.dy, r_s1.wy);
        n_s2.xwy = smul32(r_s1.dx, r_s1.wy);
        n_s2.ywx = smul32(r_s1.dy, r_s1.wx);
        n_s2.wxx = smul32(r_s1.wx, r_s1.wx);
        n_s2.wyy = smul32(r_s1.wy, r_s1.wy);
        n_s2.uxx = smul32(r_s1.ux, r_s1.ux);
        n_s2.uyy = smul32(r_s1.uy, r_s1.uy);
        n_s2.dx  = r_s1.dx;
        n_s2.dy  = r_s1.dy;
    end

    always_comb begin
        n_s3.len2 = r_s2.xx + r_s2.yy;
        n_s3.ww   = r_s2.wxx + r_s2.wyy;
        n_s3.uu   = r_s2.uxx + r_s2.uyy;
        n_s3.t    = r_s2.xw + r_s2.yw;
        n_s3.cr   = r_s2.xwy - r_s2.ywx;
        n_s3.dx   = r_s2.dx;
        n_s3.dy   = r_s2.dy;
    end

    always_comb begin
        logic tneg;
        logic tgt;
        logic crn;
        logic crp;
        tneg = r_s3.t[63];
        tgt  = !tneg && ($unsigned(r_s3.t) > r_s3.len2);
        crn  = r_s3.cr[63];
        crp  = !crn && (r_s3.cr != 64'sd0);
        n_sp[0].a.v  = r_s3.len2;
        n_sp[0].a.r  = 64'd0;
        n_sp[0].b.v  = tneg ? r_s3.ww : r_s3.uu;
        n_sp[0].b.r  = 64'd0;
        n_sp[0].acr  = crn ? 64'(-r_s3.cr) : 64'(r_s3.cr);
        n_sp[0].exm  = r_s3.dy[31] ? 32'(-r_s3.dy) : 32'(r_s3.dy);
        n_sp[0].eym  = r_s3.dx[31] ? 32'(-r_s3.dx) : 32'(r_s3.dx);
        n_sp[0].exn  = (crn && r_s3.dy < 0) || (crp && r_s3.dy > 0);
        n_sp[0].eyn  = (crn && r_s3.dx > 0) || (crp && r_s3.dx < 0);
        n_sp[0].crz  = !crn && !crp;
        n_sp[0].ok   = (r_s3.dx != 32'sd0) || (r_s3.dy != 32'sd0);
        n_sp[0].perp = !tneg && !tgt;
        for (int i = 0; i < SQ_STEPS; i++) begin
            n_sp[i+1]   = r_sp[i];
            n_sp[i+1].a = sq_step(r_sp[i].a, 6'(62 - 2 * i));
            n_sp[i+1].b = sq_step(r_sp[i].b, 6'(62 - 2 * i));
        end
    end

    always_comb begin
        n_dp[0].q    = dv_init(r_sp[SQ_STEPS].acr);
        n_dp[0].x    = dv_init({2'b00, r_sp[SQ_STEPS].exm, 30'd0});
        n_dp[0].y    = dv_init({2'b00, r_sp[SQ_STEPS].eym, 30'd0});
        n_dp[0].len  = r_sp[SQ_STEPS].a.r[31:0];
        n_dp[0].dsq  = r_sp[SQ_STEPS].b.r[31:0];
        n_dp[0].exn  = r_sp[SQ_STEPS].exn;
        n_dp[0].eyn  = r_sp[SQ_STEPS].eyn;
        n_dp[0].crz  = r_sp[SQ_STEPS].crz;
        n_dp[0].ok   = r_sp[SQ_STEPS].ok;
        n_dp[0].perp = r_sp[SQ_STEPS].perp;
        for (int i = 0; i < DV_STEPS; i++) begin
            n_dp[i+1]   = r_dp[i];
            n_dp[i+1].q = dv_step(r_dp[i].q, r_dp[i].len);
            n_dp[i+1].x = dv_step(r_dp[i].x, r_dp[i].len);
            n_dp[i+1].y = dv_step(r_dp[i].y, r_dp[i].len);
        end
    end

    always_comb begin
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        qx         = r_dp[DV_STEPS].x.lo[31:0];
        qy         = r_dp[DV_STEPS].y.lo[31:0];
        n_res.ok   = r_dp[DV_STEPS].ok;
        n_res.sep  = r_dp[DV_STEPS].perp ? r_dp[DV_STEPS].q.lo : {1'b0, r_dp[DV_STEPS].dsq};
        if (r_dp[DV_STEPS].crz) begin
            n_res.nx = 32'sd0;
            n_res.ny = 32'sd0;
        end else begin
            n_res.nx = r_dp[DV_STEPS].exn ? -qx : qx;
            n_res.ny = r_dp[DV_STEPS].eyn ? -qy : qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_sp  <= n_sp;
            r_dp  <= n_dp;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* sv/ctc_merge.sv */
module ctc_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ctc_pkg::t_lane_res i_res [ctc_pkg::N_LANES],
    input  ctc_pkg::t_side     i_side,
    input  logic [30:0]        i_radius,
    output logic               o_valid,
    output ctc_pkg::t_out      o_res
);
    import ctc_pkg::*;

    typedef struct packed {
        logic               act, hit;
        logic [1:0]         hedge;
        logic signed [31:0] nx, ny;
        logic [30:0]        pen;
        t_side              sd;
    } t_ms;

    typedef struct packed {
        logic               act, hit;
        logic [1:0]         hedge;
        logic signed [31:0] nx, ny;
        logic signed [63:0] pvx, pvy, ppx, ppy;
        t_side              sd;
    } t_r1;

    typedef struct packed {
        logic               act, hit;
        logic [1:0]         hedge;
        logic signed [31:0] nx, ny;
        logic signed [33:0] dot;
        logic signed [41:0] psx, psy;
        t_side              sd;
    } t_r2;

    typedef struct packed {
        logic               act, hit;
        logic [1:0]         hedge;
        logic signed [65:0] rx, ry;
        logic signed [41:0] psx, psy;
        t_side              sd;
    } t_r3;

    t_ms  r_ms, n_ms;
    t_r1  r_r1, n_r1;
    t_r2  r_r2, n_r2;
    t_r3  r_r3, n_r3;
    logic r_mv, r_v1, r_v2, r_v3;

    always_comb begin
        logic        have;
        logic [32:0] best;
        have       = 1'b0;
        best       = 33'd0;
        n_ms.hedge = EDGE_12;
        n_ms.nx    = 32'sd0;
        n_ms.ny    = 32'sd0;
        for (int k = 0; k < N_LANES; k++) begin
            if (i_res[k].ok && (!have || i_res[k].sep < best)) begin
                have       = 1'b1;
                best       = i_res[k].sep;
                n_ms.hedge = EDGE_CODE[k];
                n_ms.nx    = i_res[k].nx;
                n_ms.ny    = i_res[k].ny;
            end
        end
        n_ms.hit = have && (best < {2'b00, i_radius});
        n_ms.pen = i_radius - best[30:0];
        n_ms.act = n_ms.hit && (n_ms.nx != 32'sd0 || n_ms.ny != 32'sd0);
        n_ms.sd  = i_side;
    end

    always_comb begin
        n_r1.act   = r_ms.act;
        n_r1.hit   = r_ms.hit;
        n_r1.hedge = r_ms.hedge;
        n_r1.nx    = r_ms.nx;
        n_r1.ny    = r_ms.ny;
        n_r1.pvx   = smul32(r_ms.sd.vel_x, r_ms.nx);
        n_r1.pvy   = smul32(r_ms.sd.vel_y, r_ms.ny);
        n_r1.ppx   = smul32(r_ms.nx, {1'b0, r_ms.pen});
        n_r1.ppy   = smul32(r_ms.ny, {1'b0, r_ms.pen});
        n_r1.sd    = r_ms.sd;
    end

    always_comb begin
        logic signed [41:0] dw;
        dw         = trunc30(72'(r_r1.pvx + r_r1.pvy));
        n_r2.act   = r_r1.act;
        n_r2.hit   = r_r1.hit;
        n_r2.hedge = r_r1.hedge;
        n_r2.nx    = r_r1.nx;
        n_r2.ny    = r_r1.ny;
        n_r2.dot   = dw[33:0];
        n_r2.psx   = trunc30(72'(r_r1.ppx));
        n_r2.psy   = trunc30(72'(r_r1.ppy));
        n_r2.sd    = r_r1.sd;
    end

    always_comb begin
        n_r3.act   = r_r2.act;
        n_r3.hit   = r_r2.hit;
        n_r3.hedge = r_r2.hedge;
        n_r3.rx    = 66'(r_r2.nx) * 66'(r_r2.dot);
        n_r3.ry    = 66'(r_r2.ny) * 66'(r_r2.dot);
        n_r3.psx   = r_r2.psx;
        n_r3.psy   = r_r2.psy;
        n_r3.sd    = r_r2.sd;
    end

    always_comb begin
        logic signed [41:0] qx;
        logic signed [41:0] qy;
        qx             = trunc30(72'(r_r3.rx));
        qy             = trunc30(72'(r_r3.ry));
        o_res.collided = r_r3.hit;
        o_res.hit_edge = r_r3.hedge;
        if (r_r3.act) begin
            o_res.new_pos_x = sat32(42'(r_r3.sd.pos_x) + r_r3.psx);
            o_res.new_pos_y = sat32(42'(r_r3.sd.pos_y) + r_r3.psy);
            o_res.new_vel_x = sat32(42'(r_r3.sd.vel_x) - (qx <<< 1));
            o_res.new_vel_y = sat32(42'(r_r3.sd.vel_y) - (qy <<< 1));
        end else begin
            o_res.new_pos_x = r_r3.sd.pos_x;
            o_res.new_pos_y = r_r3.sd.pos_y;
            o_res.new_vel_x = r_r3.sd.vel_x;
            o_res.new_vel_y = r_r3.sd.vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_mv <= i_valid;
            r_v1 <= r_mv;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ms <= n_ms;
            r_r1 <= n_r1;
            r_r2 <= n_r2;
            r_r3 <= n_r3;
        end
    end

    assign o_valid = r_v3;

endmodule

/* sv/circle_triangle_collision_response.sv */
// The fully pipelined edge lanes take one request per cycle while the output register is free or being read.
// Each lane holds a 32-stage square root pipeline and a 33-stage divider.
// Reset is synchronous and active low: it empties the pipeline and the output
// register and sets the radius back to 1.0.
module circle_triangle_collision_response (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_radius_we,
    input  logic [30:0] i_radius_wdata,
    ctc_in_if.sink      i_in,
    ctc_out_if.source   o_out
);
    import ctc_pkg::*;

    logic [30:0] r_radius;
    logic        r_vld  [0:LANE_LAT-1];
    t_side       r_side [0:LANE_LAT-1];
    t_side       w_side_in;
    t_lane_res   w_res  [N_LANES];
    logic        w_mvalid;
    t_out        w_mres;
    logic        w_load;
    logic        w_en;
    logic        r_out_valid;
    t_out        r_out;

    assign w_load     = !r_out_valid || o_out.ready;
    assign w_en       = w_load || !w_mvalid;
    assign i_in.ready = w_en;

    assign w_side_in.pos_x = i_in.pos_x;
    assign w_side_in.pos_y = i_in.pos_y;
    assign w_side_in.vel_x = i_in.vel_x;
    assign w_side_in.vel_y = i_in.vel_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side_in;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    ctc_lane u_lane_12 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (i_in.v1_x),
        .i_ay  (i_in.v1_y),
        .i_bx  (i_in.v2_x),
        .i_by  (i_in.v2_y),
        .i_px  (i_in.pos_x),
        .i_py  (i_in.pos_y),
        .o_res (w_res[0])
    );

    ctc_lane u_lane_13 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (i_in.v1_x),
        .i_ay  (i_in.v1_y),
        .i_bx  (i_in.v3_x),
        .i_by  (i_in.v3_y),
        .i_px  (i_in.pos_x),
        .i_py  (i_in.pos_y),
        .o_res (w_res[1])
    );

    ctc_lane u_lane_23 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (i_in.v2_x),
        .i_ay  (i_in.v2_y),
        .i_bx  (i_in.v3_x),
        .i_by  (i_in.v3_y),
        .i_px  (i_in.pos_x),
        .i_py  (i_in.pos_y),
        .o_res (w_res[2])
    );

    ctc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_vld[LANE_LAT-1]),
        .i_res    (w_res),
        .i_side   (r_side[LANE_LAT-1]),
        .i_radius (r_radius),
        .o_valid  (w_mvalid),
        .o_res    (w_mres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= w_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_mres;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.new_pos_x = r_out.new_pos_x;
    assign o_out.new_pos_y = r_out.new_pos_y;
    assign o_out.new_vel_x = r_out.new_vel_x;
    assign o_out.new_vel_y = r_out.new_vel_y;
    assign o_out.collided  = r_out.collided;
    assign o_out.hit_edge  = r_out.hit_edge;

endmodule

/* sv/ctc_checker.sv */
module ctc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [130:0] i_out_data
);

    // A result that is held back must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // With the output register free, a new request is always taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request refused with empty output");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("request refused while results drain");

endmodule

bind circle_triangle_collision_response ctc_checker u_ctc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.new_pos_x, o_out.new_pos_y, o_out.new_vel_x,
                   o_out.new_vel_y, o_out.collided, o_out.hit_edge})
);
